@@ sv/sha256_stream_hasher_core_assert.svh @@
// Assertion macros for the SHA-256 stream hasher.
`ifndef SHA256_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_STREAM_HASHER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ sv/sha_pkg.sv @@
// Package with SHA-256 types, constants and round functions.
`timescale 1ns / 1ps
package sha_pkg;
  localparam int BlockBytes = 64;
  localparam int Rounds = 64;

  localparam logic [1:0] FUNC_ABSORB  = 2'd0;
  localparam logic [1:0] FUNC_FINISH  = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic [5:0] round;
  } rnd_ctrl_t;

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction
endpackage

@@ sv/sha_round.sv @@
// One SHA-256 round unit with its rolling message schedule window.
`timescale 1ns / 1ps
module sha_round (
  input  logic             clk,
  input  sha_pkg::rnd_ctrl_t ctrl,
  input  sha_pkg::word_t   chain [8],
  input  sha_pkg::word_t   block [16],
  output sha_pkg::word_t   vars [8]
);
  sha_pkg::word_t win [16];
  sha_pkg::word_t w_new;
  sha_pkg::word_t w_cur;
  sha_pkg::word_t t1;
  sha_pkg::word_t t2;
  sha_pkg::word_t w15;
  sha_pkg::word_t w2;

  always_comb begin
    w15 = win[1];
    w2 = win[14];
    w_new = win[0] + (sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3))
          + win[9] + (sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10));
    w_cur = (ctrl.round < 6'd16) ? win[0] : w_new;
    t1 = vars[7] + (sha_pkg::rotr(vars[4], 6) ^ sha_pkg::rotr(vars[4], 11)
         ^ sha_pkg::rotr(vars[4], 25)) + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6]))
         + sha_pkg::ROUND_K[ctrl.round] + w_cur;
    t2 = (sha_pkg::rotr(vars[0], 2) ^ sha_pkg::rotr(vars[0], 13) ^ sha_pkg::rotr(vars[0], 22))
         + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
  end

  // The window shifts by one word a round; slot zero is the current word in the first sixteen rounds only.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      win <= block;
      vars <= chain;
    end else begin
      for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
      win[15] <= w_cur;
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end
endmodule

@@ sv/sha256_stream_hasher_core.sv @@
// Top level of the byte-stream SHA-256 hasher.
// Each absorb stores one byte; the 64th byte of a block also starts a compression of that block.
// Finish compresses one or two padded blocks and then emits 8 output words.
// Restart reloads the initial hash values and clears the counts; the block stays ready.
// Throughput is set by the single round unit, one round per cycle; no byte is taken meanwhile.
// Synchronous reset loads the standard initial hash values and clears all counts.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_core_assert.svh"
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  sha_pkg::state_t state, state_next;

  // The message buffer is held as sixteen big-endian words, built a byte at a time.
  sha_pkg::word_t buf_w [16];
  sha_pkg::word_t chain [8];
  sha_pkg::word_t saved [8];
  sha_pkg::word_t blk [16];
  sha_pkg::word_t vars [8];
  logic [5:0]  fill;
  logic [60:0] len;
  logic [5:0]  round;
  logic        finishing;   // compressing padded blocks for a finish
  logic        second;      // a second padded block is still to come
  logic        on_second;   // the current padded block is the second one
  logic [2:0]  emit_idx;
  sha_pkg::rnd_ctrl_t ctrl;
  logic        accept;
  logic [63:0] bits;

  assign accept = in_valid && in_ready;
  assign bits = {len, 3'b000};

  // In a finish the pad is bytes below fill, 0x80 at fill, zeros, length at the end.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      for (int b = 0; b < 4; b++) begin
        logic [5:0] pos;
        pos = 6'(i * 4 + b);
        if (!finishing) begin
          blk[i][31 - b * 8 -: 8] = buf_w[i][31 - b * 8 -: 8];
        end else if (on_second) begin
          blk[i][31 - b * 8 -: 8] = (fill == 6'd0 && pos == 6'd0) ? 8'h80 : 8'h00;
        end else if (pos < fill) begin
          blk[i][31 - b * 8 -: 8] = buf_w[i][31 - b * 8 -: 8];
        end else if (pos == fill) begin
          blk[i][31 - b * 8 -: 8] = 8'h80;
        end else begin
          blk[i][31 - b * 8 -: 8] = 8'h00;
        end
      end
    end
    // The length goes in the last block of the pad.
    if (finishing && (on_second || fill < 6'd56)) begin
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
    end
  end

  assign ctrl = {(state == sha_pkg::ST_LOAD), round};

  sha_round u_round (
    .clk   (clk),
    .ctrl  (ctrl),
    .chain (chain),
    .block (blk),
    .vars  (vars)
  );

  always_comb begin
    state_next = state;
    case (state)
      sha_pkg::ST_IDLE: begin
        if (accept && func == sha_pkg::FUNC_ABSORB && fill == 6'd63) begin
          state_next = sha_pkg::ST_LOAD;
        end else if (accept && func == sha_pkg::FUNC_FINISH) begin
          state_next = sha_pkg::ST_LOAD;
        end
      end
      sha_pkg::ST_LOAD:  state_next = sha_pkg::ST_ROUND;
      sha_pkg::ST_ROUND: if (round == 6'd63) state_next = sha_pkg::ST_ADD;
      sha_pkg::ST_ADD: begin
        if (!finishing) state_next = sha_pkg::ST_IDLE;
        else if (second) state_next = sha_pkg::ST_LOAD;
        else state_next = sha_pkg::ST_EMIT;
      end
      sha_pkg::ST_EMIT: if (out_ready && emit_idx == 3'd7) state_next = sha_pkg::ST_IDLE;
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == sha_pkg::ST_IDLE);
    out_valid = (state == sha_pkg::ST_EMIT);
    digest_word = chain[emit_idx];
    word_index = emit_idx;
    last_word = (emit_idx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ST_IDLE;
      chain <= sha_pkg::INIT_H;
      saved <= sha_pkg::INIT_H;
      fill <= '0;
      len <= '0;
      round <= '0;
      finishing <= 1'b0;
      second <= 1'b0;
      on_second <= 1'b0;
      emit_idx <= '0;
    end else begin
      state <= state_next;
      case (state)
        sha_pkg::ST_IDLE: begin
          if (accept) begin
            if (func == sha_pkg::FUNC_ABSORB) begin
              buf_w[fill[5:2]][31 - 8 * fill[1:0] -: 8] <= data_byte;
              fill <= fill + 6'd1;
              len <= len + 61'd1;
            end else if (func == sha_pkg::FUNC_RESTART) begin
              chain <= sha_pkg::INIT_H;
              fill <= '0;
              len <= '0;
            end else if (func == sha_pkg::FUNC_FINISH) begin
              finishing <= 1'b1;
              second <= (fill >= 6'd56);
              on_second <= 1'b0;
              saved <= chain;
            end
          end
        end
        sha_pkg::ST_LOAD: round <= '0;
        sha_pkg::ST_ROUND: round <= round + 6'd1;
        sha_pkg::ST_ADD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + vars[i];
          if (finishing && second) begin
            second <= 1'b0;
            on_second <= 1'b1;
          end
          emit_idx <= '0;
        end
        sha_pkg::ST_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              chain <= saved;
              finishing <= 1'b0;
              on_second <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // A digest is only shown while a finish is in progress.
  `SHA_ASSERT_IMP(a_emit_finishing, clk, rst, out_valid, finishing, "digest word outside finish")
  // The block never takes a byte while it is emitting.
  `SHA_ASSERT_IMP(a_no_overlap, clk, rst, out_valid, !in_ready, "input ready during emit")
  // Completing the last word returns the block to idle.
  `SHA_ASSERT_NEXT(a_last_idle, clk, rst, out_valid && out_ready && last_word, in_ready,
                   "not idle after last digest word")
endmodule
